// ===== rtl/tsb_pkg.sv =====
// Shared types, constants and axis arithmetic for the bilinear texture sampler.
package tsb_pkg;

	// Texture size limits and coordinate format
	localparam int MAX_WIDTH       = 256;
	localparam int MAX_HEIGHT      = 256;
	localparam int MAX_TEXELS      = 65536;
	localparam int COORD_FRAC_BITS = 16;

	localparam int CF         = COORD_FRAC_BITS;
	localparam int HALF_TEXEL = 1 << (CF - 1);
	localparam int WT_SHR     = (CF >= 16) ? CF - 16 : 0;
	localparam int WT_SHL     = (CF < 16) ? 16 - CF : 0;

	localparam int DIMW_BITS  = $clog2(MAX_WIDTH + 1);
	localparam int DIMH_BITS  = $clog2(MAX_HEIGHT + 1);
	localparam int DIM_BITS   = (DIMW_BITS > DIMH_BITS) ? DIMW_BITS : DIMH_BITS;
	localparam int XB         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int YB         = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int IDX_BITS   = (XB > YB) ? XB : YB;
	localparam int ADDR_BITS  = (MAX_WIDTH * MAX_HEIGHT > 1) ?
		$clog2(MAX_WIDTH * MAX_HEIGHT) : 1;

	localparam int TEXEL_BITS = 24;
	localparam int CFG_BITS   = 9;
	localparam int CFG_IDX_BITS = 2;
	localparam int QDEPTH     = 4;

	localparam logic [15:0] WHITE_OUT = 16'hFF00;
	localparam int          WT_ONE    = 65536;

	// Operation codes of an input word
	localparam logic [1:0] OP_WRITE    = 2'd0;
	localparam logic [1:0] OP_NEAREST  = 2'd1;
	localparam logic [1:0] OP_BILINEAR = 2'd2;
	localparam logic [1:0] OP_UNUSED   = 2'd3;

	// Register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_TEX_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_TEX_HEIGHT = 2'd1;

	typedef logic [DIM_BITS-1:0]  dim_t;
	typedef logic [IDX_BITS-1:0]  idx_t;
	typedef logic [ADDR_BITS-1:0] addr_t;

	typedef enum logic [1:0] {
		K_WRITE  = 2'd0,
		K_SAMPLE = 2'd1,
		K_WHITE  = 2'd2
	} kind_t;

	typedef struct packed {
		idx_t        lo;
		idx_t        hi;
		logic [15:0] wt;
	} axis_t;

	// One classified word between front and back; taps ordered 00, 10, 01, 11
	typedef struct packed {
		kind_t                   kind;
		logic                    wr_ok;
		logic [15:0]             wr_addr;
		logic [TEXEL_BITS-1:0]   wr_data;
		logic [3:0][ADDR_BITS-1:0] addr;
		logic [3:0]              oob;
		logic [15:0]             sx;
		logic [15:0]             sy;
	} item_t;

	// Nearest index: fraction of |coord| times dim gives trunc(coord*dim) mod dim
	function automatic idx_t nearest_idx(input logic [31:0] coord, input dim_t dim);
		logic [31:0]            mag;
		logic [CF+DIM_BITS-1:0] prod;
		dim_t                   r;
		dim_t                   res;
		mag  = coord[31] ? (~coord + 32'd1) : coord;
		prod = (CF + DIM_BITS)'(mag[CF-1:0]) * (CF + DIM_BITS)'(dim);
		r    = DIM_BITS'(prod >> CF);
		res  = (coord[31] && r != '0) ? dim - r : r;
		return IDX_BITS'(res);
	endfunction

	// Bilinear axis: wrap to fraction, shift by half a texel, floor and clamp
	function automatic axis_t bilin_axis(input logic [31:0] coord, input dim_t dim);
		logic [CF+DIM_BITS:0] a;
		logic [DIM_BITS:0]    t;
		logic [CF-1:0]        s;
		axis_t                r;
		a = (CF + DIM_BITS + 1)'(coord[CF-1:0]) * (CF + DIM_BITS + 1)'(dim)
			+ (CF + DIM_BITS + 1)'(HALF_TEXEL);
		t = (DIM_BITS + 1)'(a >> CF);
		s = a[CF-1:0];
		r.lo = (t == '0) ? '0 : IDX_BITS'(t - 1'b1);
		r.hi = (t >= {1'b0, dim}) ? IDX_BITS'(dim - 1'b1) : IDX_BITS'(t);
		r.wt = 16'((32'(s) >> WT_SHR) << WT_SHL);
		return r;
	endfunction

endpackage

// ===== rtl/tsb_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module tsb_ram import tsb_pkg::*; #(
	parameter int WIDTH = TEXEL_BITS,
	parameter int DEPTH = MAX_TEXELS
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr0,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr1,
	output logic [WIDTH-1:0]                       rdata0,
	output logic [WIDTH-1:0]                       rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end

endmodule

// ===== rtl/tsb_front.sv =====
// Front end: accepts words, classifies them and forms texel addresses and weights.
module tsb_front import tsb_pkg::*; #(
	parameter int MAX_TEXELS_P = MAX_TEXELS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [15:0] texel_index,
	input  logic [7:0]  texel_red,
	input  logic [7:0]  texel_green,
	input  logic [7:0]  texel_blue,
	input  logic signed [31:0] coord_u,
	input  logic signed [31:0] coord_v,
	input  dim_t        eff_w,
	input  dim_t        eff_h,
	input  logic        q_full,
	output logic        push,
	output item_t       push_item
);

	logic        adv;
	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [15:0] idx_s1;
	logic [TEXEL_BITS-1:0] rgb_s1;
	logic [31:0] u_s1;
	logic [31:0] v_s1;

	logic        valid_s2;
	kind_t       kind_s2;
	logic [15:0] idx_s2;
	logic [TEXEL_BITS-1:0] rgb_s2;
	idx_t        x0_s2, x1_s2, y0_s2, y1_s2;
	logic [15:0] sx_s2, sy_s2;

	axis_t       ax_u, ax_v;
	idx_t        xn, yn;
	kind_t       kind_c;
	idx_t        x0_c, x1_c, y0_c, y1_c;
	logic [15:0] sx_c, sy_c;
	addr_t       row0, row1;

	assign adv      = !(valid_s2 && q_full);
	assign in_stall = !adv;

	// Stage 1: capture the word, drop unused op codes here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid && (op != OP_UNUSED);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1  <= op;
			idx_s1 <= texel_index;
			rgb_s1 <= {texel_red, texel_green, texel_blue};
			u_s1   <= coord_u;
			v_s1   <= coord_v;
		end
	end

	// Nearest is a bilinear tap with zero weights on the same texel
	always_comb begin
		ax_u = bilin_axis(u_s1, eff_w);
		ax_v = bilin_axis(v_s1, eff_h);
		xn   = nearest_idx(u_s1, eff_w);
		yn   = nearest_idx(v_s1, eff_h);
		if (op_s1 == OP_WRITE) begin
			kind_c = K_WRITE;
		end else if (eff_w == '0 || eff_h == '0) begin
			kind_c = K_WHITE;
		end else begin
			kind_c = K_SAMPLE;
		end
		if (op_s1 == OP_NEAREST) begin
			x0_c = xn;
			x1_c = xn;
			y0_c = yn;
			y1_c = yn;
			sx_c = '0;
			sy_c = '0;
		end else begin
			x0_c = ax_u.lo;
			x1_c = ax_u.hi;
			y0_c = ax_v.lo;
			y1_c = ax_v.hi;
			sx_c = ax_u.wt;
			sy_c = ax_v.wt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s2 <= kind_c;
			idx_s2  <= idx_s1;
			rgb_s2  <= rgb_s1;
			x0_s2   <= x0_c;
			x1_s2   <= x1_c;
			y0_s2   <= y0_c;
			y1_s2   <= y1_c;
			sx_s2   <= sx_c;
			sy_s2   <= sy_c;
		end
	end

	// Row-major addresses of the four taps
	always_comb begin
		row0 = ADDR_BITS'(ADDR_BITS'(y0_s2) * ADDR_BITS'(eff_w));
		row1 = ADDR_BITS'(ADDR_BITS'(y1_s2) * ADDR_BITS'(eff_w));
		push_item.kind    = kind_s2;
		push_item.wr_ok   = 32'(idx_s2) < 32'(MAX_TEXELS_P);
		push_item.wr_addr = idx_s2;
		push_item.wr_data = rgb_s2;
		push_item.addr[0] = row0 + ADDR_BITS'(x0_s2);
		push_item.addr[1] = row0 + ADDR_BITS'(x1_s2);
		push_item.addr[2] = row1 + ADDR_BITS'(x0_s2);
		push_item.addr[3] = row1 + ADDR_BITS'(x1_s2);
		for (int i = 0; i < 4; i++) begin
			push_item.oob[i] = 32'(push_item.addr[i]) >= 32'(MAX_TEXELS_P);
		end
		push_item.sx = sx_s2;
		push_item.sy = sy_s2;
	end

	assign push = valid_s2 && !q_full;

endmodule

// ===== rtl/tsb_queue.sv =====
// Short word queue between the front and back ends.
module tsb_queue import tsb_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output item_t head,
	output logic  empty,
	output logic  full
);

	localparam int PB = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	item_t           slot_q [QDEPTH];
	logic [PB-1:0]   wr_ptr_q;
	logic [PB-1:0]   rd_ptr_q;
	logic [PB:0]     count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == (PB + 1)'(QDEPTH));
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PB'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PB'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not advance on push");

endmodule

// ===== rtl/tsb_back.sv =====
// Back end: store writes, four texel reads, horizontal and vertical blend, output word.
module tsb_back import tsb_pkg::*; #(
	parameter int MAX_TEXELS_P = MAX_TEXELS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  item_t       head,
	input  logic        q_empty,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] out_red,
	output logic [15:0] out_green,
	output logic [15:0] out_blue
);

	localparam int AW = (MAX_TEXELS_P > 1) ? $clog2(MAX_TEXELS_P) : 1;

	logic                  adv;
	logic                  we;
	logic [TEXEL_BITS-1:0] rd [4];

	logic        valid_s1, white_s1;
	logic [3:0]  oob_s1;
	logic [15:0] sx_s1, sy_s1;

	logic        valid_s2, white_s2;
	logic [15:0] sy_s2;
	logic [24:0] h0_s2 [3];
	logic [24:0] h1_s2 [3];

	logic        valid_s3, white_s3;
	logic [41:0] p0_s3 [3];
	logic [41:0] p1_s3 [3];

	logic        out_valid_q;
	logic [15:0] out_ch_q [3];

	logic [TEXEL_BITS-1:0] tx [4];
	logic [16:0] wx0, wx1, wy0, wy1;
	logic [24:0] h0_c [3];
	logic [24:0] h1_c [3];
	logic [42:0] sum_c [3];
	logic [15:0] res_c [3];

	// Freeze the whole back end while a result waits on a stalled output
	assign adv = !(out_valid_q && out_stall);
	assign pop = adv && !q_empty;
	assign we  = pop && (head.kind == K_WRITE) && head.wr_ok;

	// Two copies of the store: one serves the upper row, one the lower row
	tsb_ram #(.WIDTH(TEXEL_BITS), .DEPTH(MAX_TEXELS_P)) u_ram_row0 (
		.clk    (clk),
		.we     (we),
		.waddr  (AW'(head.wr_addr)),
		.wdata  (head.wr_data),
		.re     (pop),
		.raddr0 (AW'(head.addr[0])),
		.raddr1 (AW'(head.addr[1])),
		.rdata0 (rd[0]),
		.rdata1 (rd[1])
	);

	tsb_ram #(.WIDTH(TEXEL_BITS), .DEPTH(MAX_TEXELS_P)) u_ram_row1 (
		.clk    (clk),
		.we     (we),
		.waddr  (AW'(head.wr_addr)),
		.wdata  (head.wr_data),
		.re     (pop),
		.raddr0 (AW'(head.addr[2])),
		.raddr1 (AW'(head.addr[3])),
		.rdata0 (rd[2]),
		.rdata1 (rd[3])
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= pop && (head.kind != K_WRITE);
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	// Horizontal blend of each row
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			tx[i] = oob_s1[i] ? '0 : rd[i];
		end
		wx1 = {1'b0, sx_s1};
		wx0 = 17'(WT_ONE) - wx1;
		for (int c = 0; c < 3; c++) begin
			h0_c[c] = 25'(tx[0][23-8*c -: 8]) * 25'(wx0)
				+ 25'(tx[1][23-8*c -: 8]) * 25'(wx1);
			h1_c[c] = 25'(tx[2][23-8*c -: 8]) * 25'(wx0)
				+ 25'(tx[3][23-8*c -: 8]) * 25'(wx1);
		end
	end

	assign wy1 = {1'b0, sy_s2};
	assign wy0 = 17'(WT_ONE) - wy1;

	// Round the blend, total weight 2^32, half up to 8 fraction bits
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum_c[c] = 43'(p0_s3[c]) + 43'(p1_s3[c]) + 43'(1 << 23);
			res_c[c] = white_s3 ? WHITE_OUT : sum_c[c][39:24];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			white_s1 <= head.kind == K_WHITE;
			oob_s1   <= head.oob;
			sx_s1    <= head.sx;
			sy_s1    <= head.sy;
			white_s2 <= white_s1;
			sy_s2    <= sy_s1;
			white_s3 <= white_s2;
			for (int c = 0; c < 3; c++) begin
				h0_s2[c]    <= h0_c[c];
				h1_s2[c]    <= h1_c[c];
				p0_s3[c]    <= 42'(h0_s2[c]) * 42'(wy0);
				p1_s3[c]    <= 42'(h1_s2[c]) * 42'(wy1);
				out_ch_q[c] <= res_c[c];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_red   = out_ch_q[0];
	assign out_green = out_ch_q[1];
	assign out_blue  = out_ch_q[2];

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_ch_q[0] <= WHITE_OUT && out_ch_q[1] <= WHITE_OUT
			&& out_ch_q[2] <= WHITE_OUT))
		else $error("blended channel above full intensity");

	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.kind == K_WRITE) |=> !valid_s1)
		else $error("store write entered the blend pipeline");

	a_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(valid_s1) && $stable(valid_s2) && $stable(valid_s3)))
		else $error("back end moved while output stalled");

endmodule

// ===== rtl/texture_sampler_bilinear.sv =====
// Top level of the bilinear texture sampler: configuration registers and the front/back split.
//
// Words on the input channel either write one 24-bit RGB texel to the store
// (op 0, row-major address texel_index) or sample it at signed Q15.16
// coordinates, nearest (op 1) or bilinear with edge clamping (op 2); op 3 is
// dropped. Each sample yields one output word with channels in 1/255 units and
// 8 fraction bits; with tex_width or tex_height zero a sample returns white.
// The block takes one word per clock while in_stall is low: the front end
// registers and classifies the word and forms the four tap addresses and
// weights in two stages, a four-entry queue decouples it from the back end,
// and the back end reads all four taps in the same cycle from two copies of
// the store (each with two read ports, both written by every texel write),
// then blends in three stages (horizontal, vertical, round) into the output
// register. A stalled output freezes the back end; the front keeps accepting
// until the queue fills. Write tex_width and tex_height only while no word is
// in flight. Texel storage is not reset; read only texels that were written.
module texture_sampler_bilinear import tsb_pkg::*; #(
	parameter int MAX_TEXELS_P = MAX_TEXELS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration write port
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data,
	// input words
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              op,
	input  logic [15:0]             texel_index,
	input  logic [7:0]              texel_red,
	input  logic [7:0]              texel_green,
	input  logic [7:0]              texel_blue,
	input  logic signed [31:0]      coord_u,
	input  logic signed [31:0]      coord_v,
	// output words
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [15:0]             out_red,
	output logic [15:0]             out_green,
	output logic [15:0]             out_blue
);

	logic [CFG_BITS-1:0] tex_width_q;
	logic [CFG_BITS-1:0] tex_height_q;
	dim_t                eff_w;
	dim_t                eff_h;

	logic  push;
	item_t push_item;
	logic  pop;
	item_t head;
	logic  q_empty;
	logic  q_full;

	// Register writes; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_width_q  <= '0;
			tex_height_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_TEX_WIDTH) begin
				tex_width_q <= cfg_data;
			end else if (cfg_index == REG_TEX_HEIGHT) begin
				tex_height_q <= cfg_data;
			end
		end
	end

	// Saturate oversized dimensions to the texture limits
	assign eff_w = (32'(tex_width_q) > 32'(MAX_WIDTH)) ?
		dim_t'(MAX_WIDTH) : dim_t'(tex_width_q);
	assign eff_h = (32'(tex_height_q) > 32'(MAX_HEIGHT)) ?
		dim_t'(MAX_HEIGHT) : dim_t'(tex_height_q);

	tsb_front #(.MAX_TEXELS_P(MAX_TEXELS_P)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.texel_index (texel_index),
		.texel_red   (texel_red),
		.texel_green (texel_green),
		.texel_blue  (texel_blue),
		.coord_u     (coord_u),
		.coord_v     (coord_v),
		.eff_w       (eff_w),
		.eff_h       (eff_h),
		.q_full      (q_full),
		.push        (push),
		.push_item   (push_item)
	);

	tsb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty),
		.full      (q_full)
	);

	tsb_back #(.MAX_TEXELS_P(MAX_TEXELS_P)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_empty   (q_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_red   (out_red),
		.out_green (out_green),
		.out_blue  (out_blue)
	);

endmodule
